FILE: rtl/core/spq_pkg.sv
// Shared constants and types for the stable priority queue.
package spq_pkg;

  localparam int DEPTH        = 16;
  localparam int PRIO_BITS    = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef struct packed {
    logic [PRIO_BITS-1:0]    prio;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/stable_priority_queue_top.sv
// Stable priority queue: a row of sorting cells with an entry count and result register.
// A request accepted at one edge gives its result, with done high, in the next cycle.
// Throughput: one request per cycle; busy stays low, all cells compare in parallel.
// Reset (rst, synchronous): the queue becomes empty and no result is pending.
// Results are shown for one cycle only; the receiver cannot stall them.
module stable_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [15:0] priority_req,
  input  logic [15:0] payload,
  output logic        done,
  output logic        out_valid,
  output logic [15:0] out_payload,
  output logic [15:0] out_priority,
  output logic        rejected,
  output logic        is_empty,
  output logic        is_full
);

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  spq_pkg::cell_ctrl_t       ctrl;
  spq_pkg::entry_t           new_entry;
  spq_pkg::entry_t           entries [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0] ge;
  logic [spq_pkg::DEPTH-1:0] occupied;
  logic                      full;
  logic                      empty;

  assign busy  = 1'b0;
  assign full  = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty = (count == '0);

  assign new_entry.prio = spq_pkg::PRIO_BITS'(priority_req);
  assign new_entry.pay  = spq_pkg::PAYLOAD_BITS'(payload);

  always_comb begin
    ctrl.enq   = start && (func == spq_pkg::FUNC_ENQ) && !full;
    ctrl.deq   = start && (func == spq_pkg::FUNC_DEQ) && !empty;
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + 1'b1;
    end else if (ctrl.deq) begin
      count_next = count - 1'b1;
    end
  end

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_ge;

    assign occupied[i] = (count > spq_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .occupied    (occupied[i]),
      .ge          (ge[i]),
      .entry       (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  // Result register; the payload fields need no reset.
  always_ff @(posedge clk) begin
    out_valid    <= ctrl.deq;
    out_payload  <= ctrl.deq ? 16'(entries[0].pay) : 16'd0;
    out_priority <= ctrl.deq ? 16'(entries[0].prio) : 16'd0;
    rejected     <= start && (func == spq_pkg::FUNC_ENQ) && full;
    is_empty     <= (count_next == '0);
    is_full      <= (count_next == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  end

endmodule

FILE: rtl/core/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    new_entry,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_ge,
  input  spq_pkg::entry_t    right_entry,
  input  logic               occupied,
  output logic               ge,
  output spq_pkg::entry_t    entry
);

  // A prefix of occupied cells with priority at least the new one stays put.
  assign ge = occupied && (entry.prio >= new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.enq && !ge) begin
      // first cell past the prefix takes the request, the rest shift right
      if (left_ge) begin
        entry <= new_entry;
      end else begin
        entry <= left_entry;
      end
    end else if (ctrl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the stable priority queue top level.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 1450;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    logic                             func;
    logic [spq_pkg::PRIO_BITS-1:0]    prio;
    logic [spq_pkg::PAYLOAD_BITS-1:0] pay;
    bit                               drain;
  } request_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] pay;
    logic [15:0] prio;
    logic        rejected;
    logic        empty;
    logic        full;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = spq_pkg::FUNC_ENQ;
  logic [15:0] priority_req = '0;
  logic [15:0] payload = '0;
  logic        busy;
  logic        done;
  logic        out_valid;
  logic [15:0] out_payload;
  logic [15:0] out_priority;
  logic        rejected;
  logic        is_empty;
  logic        is_full;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];

  // sorted copy of the queue contents, head at index 0
  spq_pkg::entry_t held[spq_pkg::DEPTH];
  int              held_count;

  request_t cur_req;
  int       burst_left;
  int       gap_left;
  int       idle_cycles;
  int       errors = 0;

  stable_priority_queue_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .priority_req (priority_req),
    .payload      (payload),
    .done         (done),
    .out_valid    (out_valid),
    .out_payload  (out_payload),
    .out_priority (out_priority),
    .rejected     (rejected),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

  always #5 clk = ~clk;

  function automatic void push_request(logic f, logic [15:0] p, logic [15:0] d, bit drain);
    request_t r;
    r.func  = f;
    r.prio  = p;
    r.pay   = d;
    r.drain = drain;
    pending_requests.push_back(r);
  endfunction

  function automatic outcome_t predict_queue_op(request_t req);
    outcome_t o;
    int       pos;
    o = '0;
    if (req.func == spq_pkg::FUNC_ENQ) begin
      if (held_count >= spq_pkg::DEPTH) begin
        o.rejected = 1'b1;
      end else begin
        // insert behind every entry of greater or equal priority
        pos = 0;
        while (pos < held_count && held[pos].prio >= req.prio) pos++;
        for (int i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].prio = req.prio;
        held[pos].pay  = req.pay;
        held_count++;
      end
    end else if (held_count > 0) begin
      o.valid = 1'b1;
      o.pay   = held[0].pay;
      o.prio  = held[0].prio;
      for (int i = 1; i < held_count; i++) held[i-1] = held[i];
      held_count--;
    end
    o.empty = (held_count == 0);
    o.full  = (held_count >= spq_pkg::DEPTH);
    return o;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h actual %h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      held_count = 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) expected_outcomes.push_back(predict_queue_op(cur_req));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          start <= 1'b0;
        end else if (pending_requests[0].drain && (expected_outcomes.size() != 0 || done)) begin
          // hold until every outstanding result has come back
          start <= 1'b0;
        end else begin
          cur_req = pending_requests.pop_front();
          func         <= cur_req.func;
          priority_req <= cur_req.prio;
          payload      <= cur_req.pay;
          start        <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t unexpected result: expected none actual payload %h priority %h",
                 $realtime, out_payload, out_priority);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("out_valid", 16'(want.valid), 16'(out_valid));
        check_field("out_payload", want.pay, out_payload);
        check_field("out_priority", want.prio, out_priority);
        check_field("rejected", 16'(want.rejected), 16'(rejected));
        check_field("is_empty", 16'(want.empty), 16'(is_empty));
        check_field("is_full", 16'(want.full), 16'(is_full));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int          random_count;
    int          phase_len;
    int          enq_pct;
    int          prio_mode;
    bit          drain;
    logic [15:0] p;
    logic        f;

    // directed: empty dequeue, extremes, ties at top and bottom, drain past empty
    push_request(spq_pkg::FUNC_DEQ, 16'($urandom), 16'($urandom), 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'hFFFF, 16'hFFFF, 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'h0000, 16'h0000, 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'hFFFF, 16'h0001, 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'h8000, 16'hAAAA, 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'h0000, 16'h5555, 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'h7FFF, 16'hFFFE, 1'b0);
    for (int k = 0; k < 7; k++) begin
      push_request(spq_pkg::FUNC_DEQ, 16'($urandom), 16'($urandom), 1'b0);
    end
    push_request(spq_pkg::FUNC_ENQ, 16'h0001, 16'h1234, 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'h0001, 16'h4321, 1'b0);
    push_request(spq_pkg::FUNC_ENQ, 16'h0002, 16'h0F0F, 1'b0);
    for (int k = 0; k < 4; k++) begin
      push_request(spq_pkg::FUNC_DEQ, 16'($urandom), 16'($urandom), 1'b0);
    end

    // random phases: fill-heavy, drain-heavy and mixed, with varied priority spread
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      phase_len = $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0:       enq_pct = 85;
        1:       enq_pct = 20;
        2:       enq_pct = 50;
        default: enq_pct = 65;
      endcase
      prio_mode = $urandom_range(0, 3);
      drain = (random_count == 0) || ($urandom_range(0, 5) == 0);
      for (int k = 0; k < phase_len; k++) begin
        case (prio_mode)
          0:       p = 16'($urandom_range(0, 3));
          1:       p = 16'($urandom);
          2:       p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: p = {3'($urandom_range(0, 7)), 13'h0};
        endcase
        f = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ;
        push_request(f, p, 16'($urandom), drain && (k == 0));
        random_count++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
